### src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Types, constants and a helper function shared by the buddy page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  localparam int PAGE_COUNT  = 4096;
  localparam int LEVEL_COUNT = 13;
  localparam int PAGE_W      = 12;
  localparam int LINK_W      = 13;
  localparam int LEVEL_W     = 4;
  localparam int TAG_W       = 16;

  localparam logic [LINK_W-1:0]  NIL        = LINK_W'(PAGE_COUNT);
  localparam logic [LINK_W-1:0]  LINK_ONE   = LINK_W'(1);
  localparam logic [LINK_W-1:0]  PAGE_LIM   = LINK_W'(PAGE_COUNT);
  localparam logic [LEVEL_W-1:0] LEVEL_LIM  = LEVEL_W'(LEVEL_COUNT);
  localparam logic [LEVEL_W-1:0] LEVEL_TOP  = LEVEL_W'(LEVEL_COUNT - 1);
  localparam logic [PAGE_W-1:0]  PAGE_LAST  = PAGE_W'(PAGE_COUNT - 1);

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [LEVEL_W-1:0] req_level;
    logic [PAGE_W-1:0]  page_index;
    logic [TAG_W-1:0]   tag_in;
  } request_t;

  typedef struct packed {
    logic              ok;
    logic [PAGE_W-1:0] block_page;
    logic [TAG_W-1:0]  tag_out;
  } result_t;

  typedef struct packed {
    logic               free;
    logic [LEVEL_W-1:0] level;
  } desc_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_READ_X,
    OP_READ_B,
    OP_SEL_H,
    OP_INC_K,
    OP_DEC_K,
    OP_SET_U,
    OP_UL_WR,
    OP_PUSH0,
    OP_PUSH1,
    OP_TAKE_WR,
    OP_FREE_OK,
    OP_MERGE_UPD,
    OP_ALLOC_FAIL,
    OP_FREE_FAIL
  } op_t;

  typedef struct packed {
    op_t  op;
    logic push_dec;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic lvl_bad;
    logic p_oob;
    logic head_nil;
    logic k_top;
    logic k_eq_req;
    logic x_oob;
    logic rd_free;
    logic lvl_match;
    logic merge_ok;
    logic clr_done;
  } status_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SPLIT,
    S_UL_RD,
    S_UL_WR,
    S_PUSH0,
    S_PUSH1,
    S_U_CALC,
    S_U_RD,
    S_U_CHK,
    S_NEXT_K,
    S_TAKE_WR,
    S_FREE_CHK,
    S_MERGE,
    S_MERGE_CHK,
    S_MERGE_UPD,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    RET_SPLIT_H,
    RET_SPLIT_U,
    RET_TAKE,
    RET_MERGE,
    RET_FREE
  } ret_t;

  function automatic logic [LEVEL_W-1:0] lvl_clamp(input logic [LEVEL_W-1:0] l);
    lvl_clamp = (l >= LEVEL_LIM) ? LEVEL_TOP : l;
  endfunction

endpackage

`default_nettype wire

### src/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// Descriptor memories, free list heads and working registers of the allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bpa_pkg::cmd_t                   cmd,
  output bpa_pkg::status_t                     status,
  input  wire bpa_pkg::request_t               request,
  input  wire logic                            cfg_we,
  input  wire logic [bpa_pkg::LINK_W-1:0]      cfg_wdata,
  output bpa_pkg::result_t                     result
);

  bpa_pkg::request_t                item;
  bpa_pkg::result_t                 res;
  logic [bpa_pkg::LINK_W-1:0]       x;
  logic [bpa_pkg::LINK_W-1:0]       y;
  logic [bpa_pkg::LINK_W-1:0]       hs;
  logic [bpa_pkg::LEVEL_W-1:0]      k;
  logic [bpa_pkg::PAGE_W-1:0]       ra;
  logic [bpa_pkg::LINK_W-1:0]       heads [bpa_pkg::LEVEL_COUNT];
  logic [bpa_pkg::LINK_W-1:0]       total_pages;
  logic [bpa_pkg::PAGE_W-1:0]       clr_cnt;

  logic [bpa_pkg::LINK_W-1:0]       lim;
  logic [bpa_pkg::LEVEL_W-1:0]      k_dec;
  logic [bpa_pkg::LEVEL_W-1:0]      pl;
  logic [bpa_pkg::LEVEL_W-1:0]      lvu;
  logic [bpa_pkg::LINK_W-1:0]       step_k;
  logic [bpa_pkg::LINK_W-1:0]       step_km1;
  logic [bpa_pkg::LINK_W-1:0]       b;
  logic [bpa_pkg::LINK_W-1:0]       head_k;
  logic [bpa_pkg::LINK_W-1:0]       head_pl;

  logic                             re;
  logic [bpa_pkg::PAGE_W-1:0]       raddr;
  bpa_pkg::desc_t                   desc_rd;
  logic [bpa_pkg::LINK_W-1:0]       next_rd;
  logic [bpa_pkg::LINK_W-1:0]       prev_rd;
  logic [bpa_pkg::TAG_W-1:0]        tag_rd;

  logic                             desc_we;
  logic [bpa_pkg::PAGE_W-1:0]       desc_waddr;
  bpa_pkg::desc_t                   desc_wdata;
  logic                             next_we;
  logic [bpa_pkg::PAGE_W-1:0]       next_waddr;
  logic [bpa_pkg::LINK_W-1:0]       next_wdata;
  logic                             prev_we;
  logic [bpa_pkg::PAGE_W-1:0]       prev_waddr;
  logic [bpa_pkg::LINK_W-1:0]       prev_wdata;
  logic                             tag_we;

  assign lim      = (total_pages < bpa_pkg::PAGE_LIM) ? total_pages : bpa_pkg::PAGE_LIM;
  assign k_dec    = k - 4'd1;
  assign pl       = cmd.push_dec ? k_dec : k;
  assign lvu      = bpa_pkg::lvl_clamp(desc_rd.level);
  assign step_k   = bpa_pkg::LINK_ONE << k;
  assign step_km1 = bpa_pkg::LINK_ONE << k_dec;
  assign b        = x ^ step_k;
  assign head_k   = heads[k];
  assign head_pl  = heads[pl];
  assign result   = res;

  always_comb begin
    status.kind      = item.kind;
    status.lvl_bad   = item.req_level >= bpa_pkg::LEVEL_LIM;
    status.p_oob     = x >= lim;
    status.head_nil  = head_k >= bpa_pkg::NIL;
    status.k_top     = k == bpa_pkg::LEVEL_TOP;
    status.k_eq_req  = k == item.req_level;
    status.x_oob     = x >= bpa_pkg::NIL;
    status.rd_free   = desc_rd.free;
    status.lvl_match = desc_rd.level == k;
    status.merge_ok  = (k != bpa_pkg::LEVEL_TOP) && (b < lim);
    status.clr_done  = clr_cnt == bpa_pkg::PAGE_LAST;
  end

  always_comb begin
    re         = 1'b0;
    raddr      = x[bpa_pkg::PAGE_W-1:0];
    desc_we    = 1'b0;
    desc_waddr = x[bpa_pkg::PAGE_W-1:0];
    desc_wdata = '0;
    next_we    = 1'b0;
    next_waddr = x[bpa_pkg::PAGE_W-1:0];
    next_wdata = head_pl;
    prev_we    = 1'b0;
    prev_waddr = x[bpa_pkg::PAGE_W-1:0];
    prev_wdata = bpa_pkg::NIL;
    tag_we     = 1'b0;
    unique case (cmd.op)
      bpa_pkg::OP_CLR: begin
        desc_we    = 1'b1;
        desc_waddr = clr_cnt;
      end
      bpa_pkg::OP_READ_X: begin
        re = 1'b1;
      end
      bpa_pkg::OP_READ_B: begin
        re    = 1'b1;
        raddr = b[bpa_pkg::PAGE_W-1:0];
      end
      bpa_pkg::OP_UL_WR: begin
        next_we    = prev_rd < bpa_pkg::NIL;
        next_waddr = prev_rd[bpa_pkg::PAGE_W-1:0];
        next_wdata = next_rd;
        prev_we    = next_rd < bpa_pkg::NIL;
        prev_waddr = next_rd[bpa_pkg::PAGE_W-1:0];
        prev_wdata = prev_rd;
      end
      bpa_pkg::OP_PUSH0: begin
        desc_we    = 1'b1;
        desc_wdata = '{free: 1'b1, level: pl};
        next_we    = 1'b1;
        prev_we    = 1'b1;
      end
      bpa_pkg::OP_PUSH1: begin
        prev_we    = hs < bpa_pkg::NIL;
        prev_waddr = hs[bpa_pkg::PAGE_W-1:0];
        prev_wdata = x;
      end
      bpa_pkg::OP_TAKE_WR: begin
        desc_we    = 1'b1;
        desc_wdata = '{free: 1'b0, level: desc_rd.level};
        tag_we     = 1'b1;
      end
      bpa_pkg::OP_MERGE_UPD: begin
        // upper page of the merged pair is marked used
        desc_we    = 1'b1;
        desc_waddr = (y > x) ? y[bpa_pkg::PAGE_W-1:0] : x[bpa_pkg::PAGE_W-1:0];
        desc_wdata = '{free: 1'b0, level: k};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total_pages <= bpa_pkg::PAGE_LIM;
      clr_cnt     <= '0;
      for (int i = 0; i < bpa_pkg::LEVEL_COUNT; i++) begin
        heads[i] <= bpa_pkg::NIL;
      end
    end else begin
      if (cfg_we) begin
        total_pages <= cfg_wdata;
      end
      unique case (cmd.op)
        bpa_pkg::OP_CLR: begin
          clr_cnt <= clr_cnt + 12'd1;
        end
        bpa_pkg::OP_UL_WR: begin
          if (heads[lvu] == {1'b0, ra}) begin
            heads[lvu] <= next_rd;
          end
        end
        bpa_pkg::OP_PUSH0: begin
          heads[pl] <= x;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      bpa_pkg::OP_LOAD: begin
        item <= request;
        x    <= {1'b0, request.page_index};
        k    <= request.req_level;
      end
      bpa_pkg::OP_READ_X: begin
        ra <= x[bpa_pkg::PAGE_W-1:0];
      end
      bpa_pkg::OP_READ_B: begin
        ra <= b[bpa_pkg::PAGE_W-1:0];
        y  <= b;
      end
      bpa_pkg::OP_SEL_H: begin
        x <= head_k;
      end
      bpa_pkg::OP_INC_K: begin
        k <= k + 4'd1;
      end
      bpa_pkg::OP_DEC_K: begin
        k <= k_dec;
      end
      bpa_pkg::OP_SET_U: begin
        x <= x + step_km1;
      end
      bpa_pkg::OP_PUSH0: begin
        hs <= head_pl;
      end
      bpa_pkg::OP_TAKE_WR: begin
        res <= '{ok: 1'b1, block_page: x[bpa_pkg::PAGE_W-1:0], tag_out: item.tag_in};
      end
      bpa_pkg::OP_FREE_OK: begin
        res <= '{ok: 1'b1, block_page: item.page_index, tag_out: tag_rd};
        k   <= lvu;
      end
      bpa_pkg::OP_MERGE_UPD: begin
        if (y < x) begin
          x <= y;
        end
        k <= k + 4'd1;
      end
      bpa_pkg::OP_ALLOC_FAIL: begin
        res <= '0;
      end
      bpa_pkg::OP_FREE_FAIL: begin
        res <= '{ok: 1'b0, block_page: item.page_index, tag_out: '0};
      end
      default: begin
      end
    endcase
  end

  bpa_ram #(.WIDTH(bpa_pkg::LEVEL_W + 1), .DEPTH(bpa_pkg::PAGE_COUNT)) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (desc_waddr),
    .wdata (desc_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (desc_rd)
  );

  bpa_ram #(.WIDTH(bpa_pkg::LINK_W), .DEPTH(bpa_pkg::PAGE_COUNT)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (next_rd)
  );

  bpa_ram #(.WIDTH(bpa_pkg::LINK_W), .DEPTH(bpa_pkg::PAGE_COUNT)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (prev_rd)
  );

  bpa_ram #(.WIDTH(bpa_pkg::TAG_W), .DEPTH(bpa_pkg::PAGE_COUNT)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (x[bpa_pkg::PAGE_W-1:0]),
    .wdata (item.tag_in),
    .re    (re),
    .raddr (raddr),
    .rdata (tag_rd)
  );

endmodule

`default_nettype wire

### src/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for allocate (scan, split, take) and free (check, merge, push).
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  output logic                   done,
  output bpa_pkg::cmd_t          cmd,
  input  wire bpa_pkg::status_t  status
);

  bpa_pkg::state_t state, state_next;
  bpa_pkg::ret_t   ret, ret_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpa_pkg::S_CLEAR;
      ret   <= bpa_pkg::RET_FREE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  always_comb begin
    state_next   = state;
    ret_next     = ret;
    cmd.op       = bpa_pkg::OP_NOP;
    cmd.push_dec = ret != bpa_pkg::RET_FREE;
    busy         = state != bpa_pkg::S_IDLE;
    done         = state == bpa_pkg::S_OUT;
    unique case (state)
      bpa_pkg::S_CLEAR: begin
        cmd.op = bpa_pkg::OP_CLR;
        if (status.clr_done) begin
          state_next = bpa_pkg::S_IDLE;
        end
      end
      bpa_pkg::S_IDLE: begin
        if (start) begin
          cmd.op     = bpa_pkg::OP_LOAD;
          state_next = bpa_pkg::S_DECODE;
        end
      end
      bpa_pkg::S_DECODE: begin
        if (status.kind == bpa_pkg::KIND_ALLOC) begin
          if (status.lvl_bad) begin
            cmd.op     = bpa_pkg::OP_ALLOC_FAIL;
            state_next = bpa_pkg::S_OUT;
          end else begin
            state_next = bpa_pkg::S_SCAN;
          end
        end else if (status.p_oob) begin
          cmd.op     = bpa_pkg::OP_FREE_FAIL;
          state_next = bpa_pkg::S_OUT;
        end else begin
          cmd.op     = bpa_pkg::OP_READ_X;
          state_next = bpa_pkg::S_FREE_CHK;
        end
      end
      bpa_pkg::S_SCAN: begin
        if (!status.head_nil) begin
          state_next = bpa_pkg::S_SPLIT;
        end else if (status.k_top) begin
          cmd.op     = bpa_pkg::OP_ALLOC_FAIL;
          state_next = bpa_pkg::S_OUT;
        end else begin
          cmd.op = bpa_pkg::OP_INC_K;
        end
      end
      bpa_pkg::S_SPLIT: begin
        if (status.head_nil) begin
          cmd.op     = bpa_pkg::OP_ALLOC_FAIL;
          state_next = bpa_pkg::S_OUT;
        end else begin
          cmd.op     = bpa_pkg::OP_SEL_H;
          ret_next   = status.k_eq_req ? bpa_pkg::RET_TAKE : bpa_pkg::RET_SPLIT_H;
          state_next = bpa_pkg::S_UL_RD;
        end
      end
      bpa_pkg::S_UL_RD: begin
        cmd.op     = bpa_pkg::OP_READ_X;
        state_next = bpa_pkg::S_UL_WR;
      end
      bpa_pkg::S_UL_WR: begin
        cmd.op = bpa_pkg::OP_UL_WR;
        unique case (ret)
          bpa_pkg::RET_TAKE:  state_next = bpa_pkg::S_TAKE_WR;
          bpa_pkg::RET_MERGE: state_next = bpa_pkg::S_MERGE_UPD;
          default:            state_next = bpa_pkg::S_PUSH0;
        endcase
      end
      bpa_pkg::S_PUSH0: begin
        cmd.op     = bpa_pkg::OP_PUSH0;
        state_next = bpa_pkg::S_PUSH1;
      end
      bpa_pkg::S_PUSH1: begin
        cmd.op = bpa_pkg::OP_PUSH1;
        unique case (ret)
          bpa_pkg::RET_SPLIT_H: state_next = bpa_pkg::S_U_CALC;
          bpa_pkg::RET_SPLIT_U: state_next = bpa_pkg::S_NEXT_K;
          default:              state_next = bpa_pkg::S_OUT;
        endcase
      end
      bpa_pkg::S_U_CALC: begin
        cmd.op     = bpa_pkg::OP_SET_U;
        ret_next   = bpa_pkg::RET_SPLIT_U;
        state_next = bpa_pkg::S_U_RD;
      end
      bpa_pkg::S_U_RD: begin
        if (status.x_oob) begin
          state_next = bpa_pkg::S_NEXT_K;
        end else begin
          cmd.op     = bpa_pkg::OP_READ_X;
          state_next = bpa_pkg::S_U_CHK;
        end
      end
      bpa_pkg::S_U_CHK: begin
        state_next = status.rd_free ? bpa_pkg::S_UL_WR : bpa_pkg::S_PUSH0;
      end
      bpa_pkg::S_NEXT_K: begin
        cmd.op     = bpa_pkg::OP_DEC_K;
        state_next = bpa_pkg::S_SPLIT;
      end
      bpa_pkg::S_TAKE_WR: begin
        cmd.op     = bpa_pkg::OP_TAKE_WR;
        state_next = bpa_pkg::S_OUT;
      end
      bpa_pkg::S_FREE_CHK: begin
        if (status.rd_free) begin
          cmd.op     = bpa_pkg::OP_FREE_FAIL;
          state_next = bpa_pkg::S_OUT;
        end else begin
          cmd.op     = bpa_pkg::OP_FREE_OK;
          state_next = bpa_pkg::S_MERGE;
        end
      end
      bpa_pkg::S_MERGE: begin
        if (status.merge_ok) begin
          cmd.op     = bpa_pkg::OP_READ_B;
          ret_next   = bpa_pkg::RET_MERGE;
          state_next = bpa_pkg::S_MERGE_CHK;
        end else begin
          ret_next   = bpa_pkg::RET_FREE;
          state_next = bpa_pkg::S_PUSH0;
        end
      end
      bpa_pkg::S_MERGE_CHK: begin
        if (status.rd_free && status.lvl_match) begin
          state_next = bpa_pkg::S_UL_WR;
        end else begin
          ret_next   = bpa_pkg::RET_FREE;
          state_next = bpa_pkg::S_PUSH0;
        end
      end
      bpa_pkg::S_MERGE_UPD: begin
        cmd.op     = bpa_pkg::OP_MERGE_UPD;
        state_next = bpa_pkg::S_MERGE;
      end
      bpa_pkg::S_OUT: begin
        state_next = bpa_pkg::S_IDLE;
      end
      default: begin
        state_next = bpa_pkg::S_IDLE;
      end
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
  a_done_while_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

endmodule

`default_nettype wire

### src/buddy_page_allocator_top.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator_top
// Page-granular buddy allocator with per-level free lists and merge on free.
// Allocate scans up past empty levels, then splits blocks down to the requested
// level; free merges step by step while the buddy is free at the same level, then
// pushes the block; failures finish sooner. One item at a
// time, the next accepted the cycle after the strobe; the receiver cannot stall.
// After reset a clearing pass marks all pages used; busy is high.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_page_allocator_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire bpa_pkg::request_t           request,
  output logic                             done,
  output bpa_pkg::result_t                 result,
  input  wire logic                        cfg_we,
  input  wire logic [bpa_pkg::LINK_W-1:0]  cfg_wdata
);

  bpa_pkg::cmd_t    cmd;
  bpa_pkg::status_t status;

  bpa_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  bpa_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .result    (result)
  );

endmodule

`default_nettype wire
